[src/command_frame_crc16_encoder_core_defines.svh]
// Assertion macros shared by the command frame encoder checkers
`ifndef COMMAND_FRAME_CRC16_ENCODER_CORE_DEFINES_SVH
`define COMMAND_FRAME_CRC16_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CFCE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfce check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CFCE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfce check failed");

`endif

[src/cfce_pkg.sv]
// Types, constants, microcode ROM and CRC step for the command frame encoder
package cfce_pkg;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int STEP_W = 3;

   // byte source select
   localparam logic [2:0] SRC_HDR    = 3'd0;
   localparam logic [2:0] SRC_DEV    = 3'd1;
   localparam logic [2:0] SRC_REG    = 3'd2;
   localparam logic [2:0] SRC_DATA   = 3'd3;
   localparam logic [2:0] SRC_CRC_LO = 3'd4;
   localparam logic [2:0] SRC_CRC_HI = 3'd5;

   // jump conditions
   localparam logic [1:0] JMP_NONE     = 2'd0;
   localparam logic [1:0] JMP_CNT_ZERO = 2'd1;
   localparam logic [1:0] JMP_CNT_MORE = 2'd2;

   typedef struct packed {
      logic [2:0]        src;
      logic              feed;
      logic              shift;
      logic              last;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
      logic              fin;
   } cfce_ctrl_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_one;
   } cfce_stat_type;

   // microcode: header, device, register, data loop, CRC low, CRC high
   function automatic cfce_ctrl_type cfce_rom(input logic [STEP_W-1:0] step);
      cfce_ctrl_type w;
      w = '0;
      unique case (step)
         3'd0: begin
            w.src  = SRC_HDR;
            w.feed = 1'b1;
         end
         3'd1: begin
            w.src  = SRC_DEV;
            w.feed = 1'b1;
         end
         3'd2: begin
            w.src    = SRC_REG;
            w.feed   = 1'b1;
            w.cond   = JMP_CNT_ZERO;
            w.target = 3'd4;
         end
         3'd3: begin
            w.src    = SRC_DATA;
            w.feed   = 1'b1;
            w.shift  = 1'b1;
            w.cond   = JMP_CNT_MORE;
            w.target = 3'd3;
         end
         3'd4: begin
            w.src = SRC_CRC_LO;
         end
         3'd5: begin
            w.src  = SRC_CRC_HI;
            w.last = 1'b1;
            w.fin  = 1'b1;
         end
         default: begin
            w.fin = 1'b1;
         end
      endcase
      return w;
   endfunction

   // one byte through the reflected CRC, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[src/cfce_seq.sv]
// Microcode sequencer: step counter, ROM lookup and conditional jumps
module cfce_seq
   import cfce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          advance,
   input  cfce_stat_type stat,
   output cfce_ctrl_type ctrl,
   output logic          busy
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              take_jump;

   assign ctrl = cfce_rom(step_ff);
   assign busy = busy_ff;

   always_comb begin
      unique case (ctrl.cond)
         JMP_NONE:     take_jump = 1'b0;
         JMP_CNT_ZERO: take_jump = stat.cnt_zero;
         JMP_CNT_MORE: take_jump = !stat.cnt_one;
         default:      take_jump = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (advance) begin
         if (ctrl.fin) begin
            busy_in = 1'b0;
         end else if (take_jump) begin
            step_in = ctrl.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

[src/command_frame_crc16_encoder_core.sv]
// Command frame encoder: serializes a command into bytes with a CRC-16 trailer
// The first byte of an item passes the sequencer step register, then the output register, to rsp_.
// Each item is a frame of 5 + count bytes (5..13), one byte per microcode step;
//   the next item is taken in the cycle the final CRC byte is produced.
// A stalled rsp_ channel holds the sequencer; the output register sits between.
// Reset (synchronous, active high) clears the sequencer and the output valid.
module command_frame_crc16_encoder_core
   import cfce_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_frame_type,
   input  logic [2:0]  req_request_type,
   input  logic [3:0]  req_data_count,
   input  logic [7:0]  req_device_address,
   input  logic [7:0]  req_register_address,
   input  logic [63:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte
);

   localparam logic [3:0] MaxCnt = 4'(MAX_PAYLOAD_BYTES);

   // latched command
   logic [7:0]  hdr_ff;
   logic [7:0]  dev_ff;
   logic [7:0]  reg_ff;
   logic [63:0] pay_ff;
   logic [3:0]  cnt_ff;        // data bytes still to send
   logic [15:0] crc_ff, crc_in;

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   cfce_ctrl_type ctrl;
   cfce_stat_type stat;
   logic          busy;
   logic          advance;
   logic          start;
   logic [3:0]    cnt_sat;
   logic [7:0]    cur_byte;

   // sequencer steps only when the output slot is free or being emptied
   assign advance   = busy && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy || (advance && ctrl.fin);
   assign start     = req_valid && req_ready;

   assign stat.cnt_zero = (cnt_ff == 4'd0);
   assign stat.cnt_one  = (cnt_ff == 4'd1);

   assign cnt_sat = (req_data_count > MaxCnt) ? MaxCnt : req_data_count;

   cfce_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .advance (advance),
      .stat    (stat),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   // datapath byte mux driven by the control word
   always_comb begin
      case (ctrl.src)
         SRC_HDR:    cur_byte = hdr_ff;
         SRC_DEV:    cur_byte = dev_ff;
         SRC_REG:    cur_byte = reg_ff;
         SRC_DATA:   cur_byte = pay_ff[7:0];
         SRC_CRC_LO: cur_byte = crc_ff[7:0];
         SRC_CRC_HI: cur_byte = crc_ff[15:8];
         default:    cur_byte = 8'h00;
      endcase
   end

   assign crc_in = crc_byte(crc_ff, cur_byte);

   // command latch and running CRC; a new item may load while the last byte leaves
   always_ff @(posedge clock) begin
      if (start) begin
         hdr_ff <= {req_frame_type, req_request_type, cnt_sat};
         dev_ff <= req_device_address;
         reg_ff <= req_register_address;
         pay_ff <= req_data_word;
         cnt_ff <= cnt_sat;
         crc_ff <= 16'h0000;
      end else if (advance) begin
         if (ctrl.feed) begin
            crc_ff <= crc_in;
         end
         if (ctrl.shift) begin
            pay_ff <= pay_ff >> 8;
            cnt_ff <= cnt_ff - 4'd1;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= ctrl.last;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;

endmodule

[src/cfce_checker.sv]
// Port-level checker for the command frame encoder, bound to the top level
`include "command_frame_crc16_encoder_core_defines.svh"

module cfce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_byte
);

   logic rsp_stalled;

   assign rsp_stalled = rsp_valid && !rsp_ready;

   // stalled result holds
   `CFCE_ASSERT_NEXT(a_rsp_hold, rsp_stalled, rsp_valid && $stable({rsp_frame_byte, rsp_last_byte}))

   // a frame is at least five bytes, so no item right after one is taken
   `CFCE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // a stalled mid-frame byte keeps the input closed
   `CFCE_ASSERT_NOW(a_no_accept_mid_frame, rsp_stalled && !rsp_last_byte, !req_ready)

endmodule

bind command_frame_crc16_encoder_core cfce_checker u_cfce_checker (.*);

[bench/command_frame_crc16_encoder_core_tb.sv]
// Self-checking testbench for the command frame encoder: frame bytes and CRC-16 trailer
module command_frame_crc16_encoder_core_tb;

   // Payload cap of the block and the CRC polynomial (reflected form)
   localparam int          PAYLOAD_CAP   = 8;
   localparam logic [15:0] CRC16_POLY    = 16'hA001;
   localparam int          RESET_CYCLES  = 9;
   localparam int          RANDOM_ITEMS  = 142;
   // Long receiver hold-off, long enough for the sender side to back up
   localparam int          HOLD_CYCLES   = 300;
   // Cycles to keep watching the output once nothing is expected
   localparam int          TAIL_CYCLES   = 20;
   // Worst case is roughly 160 items x 13 bytes x the longest receiver stall plus the hold-off
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          NUM_DIRECTED  = 18;

   // One command as the sender offers it. Rows with has_hdr carry a header byte
   // typed in by hand; it replaces the predicted header byte in the expectation.
   typedef struct packed {
      logic        ftype;
      logic [2:0]  rtype;
      logic [3:0]  count;
      logic [7:0]  dev_byte;
      logic [7:0]  reg_byte;
      logic [63:0] data;
      logic        has_hdr;
      logic [7:0]  hdr_byte;
   } cmd_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_frame_type;
   logic [2:0]  req_request_type;
   logic [3:0]  req_data_count;
   logic [7:0]  req_device_address;
   logic [7:0]  req_register_address;
   logic [63:0] req_data_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;

   frame_byte_type pending_frame_bytes[$];
   frame_byte_type head_byte;
   int             error_count;
   int             cycle_count;
   int             commands_accepted;

   // Directed commands: reset-like zero frame, all-ones extremes, count
   // saturation, every request type, every count, ignored payload bytes.
   cmd_row_type directed_rows [NUM_DIRECTED] = '{
      '{1'b0, 3'd0, 4'd0,  8'h00, 8'h00, 64'h0000000000000000, 1'b1, 8'h00},
      '{1'b1, 3'd7, 4'd8,  8'hFF, 8'hFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 8'hF8},
      '{1'b1, 3'd7, 4'd15, 8'hFF, 8'hFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 8'hF8},
      '{1'b0, 3'd0, 4'd9,  8'h00, 8'h00, 64'h0123456789ABCDEF, 1'b1, 8'h08},
      '{1'b1, 3'd0, 4'd12, 8'h5A, 8'hA5, 64'hFEDCBA9876543210, 1'b1, 8'h88},
      '{1'b0, 3'd1, 4'd1,  8'h01, 8'h80, 64'hFFFFFFFFFFFFFF3C, 1'b0, 8'h00},
      '{1'b1, 3'd2, 4'd2,  8'h80, 8'h01, 64'hAAAAAAAAAAAA55AA, 1'b0, 8'h00},
      '{1'b0, 3'd3, 4'd3,  8'h12, 8'h34, 64'hDEADBEEF00C0FFEE, 1'b0, 8'h00},
      '{1'b1, 3'd4, 4'd4,  8'hC3, 8'h3C, 64'h0F0F0F0FF0F0F0F0, 1'b0, 8'h00},
      '{1'b0, 3'd5, 4'd5,  8'h7F, 8'hFE, 64'h8000000000000001, 1'b0, 8'h00},
      '{1'b1, 3'd6, 4'd6,  8'h55, 8'hAA, 64'h1122334455667788, 1'b0, 8'h00},
      '{1'b0, 3'd7, 4'd7,  8'hE7, 8'h18, 64'h99AABBCCDDEEFF00, 1'b0, 8'h00},
      '{1'b1, 3'd3, 4'd8,  8'h96, 8'h69, 64'h0000000000000000, 1'b0, 8'h00},
      '{1'b0, 3'd5, 4'd0,  8'h80, 8'h01, 64'hFFFFFFFFFFFFFFFF, 1'b0, 8'h00},
      '{1'b1, 3'd1, 4'd10, 8'h0F, 8'hF0, 64'h7766554433221100, 1'b0, 8'h00},
      '{1'b0, 3'd6, 4'd13, 8'hFF, 8'h00, 64'h00FF00FF00FF00FF, 1'b0, 8'h00},
      '{1'b1, 3'd2, 4'd14, 8'h00, 8'hFF, 64'hFF00FF00FF00FF00, 1'b0, 8'h00},
      '{1'b0, 3'd4, 4'd11, 8'h3A, 8'hC5, 64'h8421842184218421, 1'b0, 8'h00}
   };

   command_frame_crc16_encoder_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_frame_type       (req_frame_type),
      .req_request_type     (req_request_type),
      .req_data_count       (req_data_count),
      .req_device_address   (req_device_address),
      .req_register_address (req_register_address),
      .req_data_word        (req_data_word),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_last_byte        (rsp_last_byte)
   );

   // 10-unit clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake ends the run here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("command_frame_crc16_encoder_core verification failed");
      $finish;
   end

   // Reflected CRC-16, LSB first, one byte at a time
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        lsb;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         lsb = c[0];
         c   = {1'b0, c[15:1]};
         if (lsb) begin
            c = c ^ CRC16_POLY;
         end
      end
      return c;
   endfunction

   // Builds the whole frame of one accepted command and queues its bytes.
   // CRC restarts at zero each frame and covers header through last data byte.
   function automatic void predict_frame(input cmd_row_type c);
      logic [3:0]     n;
      logic [7:0]     hdr;
      logic [7:0]     b;
      logic [15:0]    crc;
      frame_byte_type e;
      n   = (c.count > PAYLOAD_CAP) ? 4'(PAYLOAD_CAP) : c.count;
      hdr = {c.ftype, c.rtype, n};
      crc = 16'h0000;
      for (int i = 0; i < 3 + int'(n); i++) begin
         if (i == 0) begin
            b = hdr;
         end else if (i == 1) begin
            b = c.dev_byte;
         end else if (i == 2) begin
            b = c.reg_byte;
         end else begin
            b = 8'(c.data >> (8 * (i - 3)));
         end
         crc     = crc16_step(crc, b);
         e.value = (i == 0 && c.has_hdr) ? c.hdr_byte : b;
         e.last  = 1'b0;
         pending_frame_bytes.push_back(e);
      end
      // trailer: low byte, then high byte flagged last
      e.value = crc[7:0];
      e.last  = 1'b0;
      pending_frame_bytes.push_back(e);
      e.value = crc[15:8];
      e.last  = 1'b1;
      pending_frame_bytes.push_back(e);
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offers one item; entered and left at a falling edge. When the gap is zero,
   // valid simply stays high and only the payload moves to the next item.
   task automatic offer_command(input cmd_row_type c, input int gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_frame_type       = c.ftype;
      req_request_type     = c.rtype;
      req_data_count       = c.count;
      req_device_address   = c.dev_byte;
      req_register_address = c.reg_byte;
      req_data_word        = c.data;
      req_valid            = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_frame(c);
      commands_accepted++;
      @(negedge clock);
   endtask

   function automatic cmd_row_type random_command();
      cmd_row_type c;
      c.ftype    = 1'($urandom);
      c.rtype    = 3'($urandom);
      // mostly legal counts, some above the cap to hit saturation
      c.count    = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, PAYLOAD_CAP))
                                                : 4'($urandom_range(PAYLOAD_CAP + 1, 15));
      c.dev_byte = 8'($urandom);
      c.reg_byte = 8'($urandom);
      c.data     = {$urandom, $urandom};
      c.has_hdr  = 1'b0;
      c.hdr_byte = 8'h00;
      return c;
   endfunction

   // Sender: reset, directed table, random items, drain, verdict
   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_frame_type       = 1'b0;
      req_request_type     = 3'd0;
      req_data_count       = 4'd0;
      req_device_address   = 8'h00;
      req_register_address = 8'h00;
      req_data_word        = 64'h0;
      error_count          = 0;
      cycle_count          = 0;
      commands_accepted    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer_command(directed_rows[i], pick_gap());
      end

      // a burst window with no sender gaps sits in the middle of the random part
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         offer_command(random_command(), (i >= 60 && i < 90) ? 0 : pick_gap());
      end
      req_valid = 1'b0;

      while (pending_frame_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("command_frame_crc16_encoder_core verification clean");
      end else begin
         $display("command_frame_crc16_encoder_core verification failed");
      end
      $finish;
   end

   // Receiver: random stalls, an always-ready stretch, and one long hold-off
   // while the sender keeps offering, so the block backs up and drops req_ready.
   initial begin
      int stall_left;
      bit hold_done;
      int r;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      do begin
         @(negedge clock);
      end while (reset);
      forever begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if (!hold_done && commands_accepted >= 40) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready  = 1'b0;
         end else if (commands_accepted >= 120 && commands_accepted < 140) begin
            rsp_ready = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready = 1'b1;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 3);
               rsp_ready  = 1'b0;
            end else begin
               stall_left = $urandom_range(8, 40);
               rsp_ready  = 1'b0;
            end
         end
         @(negedge clock);
      end
   end

   // Checker: every accepted byte against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frame_bytes.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual byte %02h last %0b",
                     $time, rsp_frame_byte, rsp_last_byte);
            error_count++;
         end else begin
            head_byte = pending_frame_bytes.pop_front();
            if (rsp_frame_byte !== head_byte.value) begin
               $display("%0t: frame_byte mismatch: expected %02h actual %02h",
                        $time, head_byte.value, rsp_frame_byte);
               error_count++;
            end
            if (rsp_last_byte !== head_byte.last) begin
               $display("%0t: last_byte mismatch: expected %0b actual %0b",
                        $time, head_byte.last, rsp_last_byte);
               error_count++;
            end
         end
      end
   end

endmodule

[filelist.f]
+incdir+src
src/cfce_pkg.sv
src/cfce_seq.sv
src/command_frame_crc16_encoder_core.sv
src/cfce_checker.sv
bench/command_frame_crc16_encoder_core_tb.sv
